// ----- design/wpl_pkg.sv -----
// Shared types, constants and register indexes for the well pump level controller.
package wpl_pkg;

   localparam int TICKS_PER_SECOND_DEF = 10;

   localparam int RUN_MIN_W  = 8;
   localparam int IDLE_W     = 12;
   localparam int ABLINK_W   = 4;
   localparam int SEC_W      = 14;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN_MINUTES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_BLINK_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_BLINK_TICKS = 2'd2;

   localparam logic [RUN_MIN_W-1:0] MAX_RUN_MINUTES_RST  = 8'd15;
   localparam logic [IDLE_W-1:0]    IDLE_BLINK_LIMIT_RST = 12'd300;
   localparam logic [ABLINK_W-1:0]  AUTO_BLINK_TICKS_RST = 4'd10;
   localparam int                   BLINK_HALF_RST       = 10;

   localparam int SECONDS_PER_MINUTE = 60;
   localparam int MS_PER_SECOND      = 1000;
   localparam int MS_MANUAL_1        = 200;
   localparam int MS_MANUAL_5        = 500;
   localparam int MS_MANUAL_10       = 700;
   localparam int MINUTES_MANUAL_1   = 1;
   localparam int MINUTES_MANUAL_5   = 5;
   localparam int MINUTES_MANUAL_10  = 10;

   typedef enum logic [1:0] {
      MODE_WAIT   = 2'd0,
      MODE_CHECK  = 2'd1,
      MODE_RUN    = 2'd2,
      MODE_MANUAL = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STOP_NONE  = 2'd0,
      STOP_FULL  = 2'd1,
      STOP_EMPTY = 2'd2
   } stop_type;

   typedef enum logic [1:0] {
      MANUAL_NONE = 2'd0,
      MANUAL_1MIN = 2'd1,
      MANUAL_5MIN = 2'd2,
      MANUAL_10MIN = 2'd3
   } manual_type;

   typedef struct packed {
      logic       tick;
      logic       well_high_level;
      logic       tank_low_level;
      logic       tank_full_event;
      logic       well_empty_event;
      logic [1:0] manual_request;
   } req_type;

   typedef struct packed {
      logic       motor_on;
      logic       led_blue;
      logic       led_board;
      logic       led_green;
      logic       led_yellow;
      logic [1:0] mode;
   } rsp_type;

   typedef struct packed {
      logic [RUN_MIN_W-1:0] max_run_minutes;
      logic [IDLE_W-1:0]    idle_blink_limit;
      logic [ABLINK_W-1:0]  auto_blink_ticks;
   } cfg_type;

endpackage

// ----- design/wpl_core.sv -----
// Controller state and the per-item next-state logic.
module wpl_core #(
   parameter int TICKS_PER_SECOND = wpl_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  wpl_pkg::req_type item,
   input  wpl_pkg::cfg_type cfg,
   output wpl_pkg::rsp_type rsp_next
);
   import wpl_pkg::*;

   localparam int SUB_W          = $clog2(TICKS_PER_SECOND);
   localparam int HALF_1_RAW     = TICKS_PER_SECOND * MS_MANUAL_1 / MS_PER_SECOND;
   localparam int HALF_5_RAW     = TICKS_PER_SECOND * MS_MANUAL_5 / MS_PER_SECOND;
   localparam int HALF_10_RAW    = TICKS_PER_SECOND * MS_MANUAL_10 / MS_PER_SECOND;
   localparam int HALF_MAX       = (HALF_10_RAW + 1 > 16) ? HALF_10_RAW + 1 : 16;
   localparam int BLINK_W        = $clog2(HALF_MAX);
   localparam int MTICKS_MAX     = MINUTES_MANUAL_10 * SECONDS_PER_MINUTE * TICKS_PER_SECOND;
   localparam int MTICK_W        = $clog2(MTICKS_MAX + 1);

   localparam logic [SUB_W-1:0]   SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);
   localparam logic [BLINK_W-1:0] HALF_1   = BLINK_W'((HALF_1_RAW == 0) ? 1 : HALF_1_RAW);
   localparam logic [BLINK_W-1:0] HALF_5   = BLINK_W'((HALF_5_RAW == 0) ? 1 : HALF_5_RAW);
   localparam logic [BLINK_W-1:0] HALF_10  = BLINK_W'((HALF_10_RAW == 0) ? 1 : HALF_10_RAW);
   localparam logic [BLINK_W-1:0] HALF_RST = BLINK_W'(BLINK_HALF_RST);
   localparam logic [MTICK_W-1:0] MTICKS_1 =
      MTICK_W'(MINUTES_MANUAL_1 * SECONDS_PER_MINUTE * TICKS_PER_SECOND);
   localparam logic [MTICK_W-1:0] MTICKS_5 =
      MTICK_W'(MINUTES_MANUAL_5 * SECONDS_PER_MINUTE * TICKS_PER_SECOND);
   localparam logic [MTICK_W-1:0] MTICKS_10 =
      MTICK_W'(MINUTES_MANUAL_10 * SECONDS_PER_MINUTE * TICKS_PER_SECOND);
   localparam logic [SEC_W-1:0]   SEC_PER_MIN = SEC_W'(SECONDS_PER_MINUTE);

   mode_type             phase_ff, phase_in;
   logic [SUB_W-1:0]     sub_ff, sub_in;
   logic [SEC_W-1:0]     sec_ff, sec_in;
   logic [IDLE_W-1:0]    idle_ff, idle_in;
   stop_type             pend_ff, pend_in;
   logic                 manual_ff, manual_in;
   logic [MTICK_W-1:0]   mticks_ff, mticks_in;
   logic [BLINK_W-1:0]   half_ff, half_in;
   logic [BLINK_W-1:0]   bcnt_ff, bcnt_in;
   logic                 motor_ff, motor_in;
   logic                 blue_ff, blue_in;
   logic                 board_ff, board_in;
   logic                 green_ff, green_in;
   logic                 yellow_ff, yellow_in;

   stop_type             pend_now;
   logic                 idle_go;
   logic                 blink_go;
   logic [IDLE_W:0]      idle_inc;
   logic [BLINK_W:0]     bcnt_inc;
   logic [MTICK_W-1:0]   mticks_dec;
   logic [SEC_W-1:0]     run_limit;

   assign idle_inc   = {1'b0, idle_ff} + 1'b1;
   assign bcnt_inc   = {1'b0, bcnt_ff} + 1'b1;
   assign run_limit  = SEC_W'(cfg.max_run_minutes) * SEC_PER_MIN;
   assign mticks_dec = (mticks_ff != '0) ? mticks_ff - 1'b1 : mticks_ff;

   always_comb begin
      phase_in  = phase_ff;
      sub_in    = sub_ff;
      sec_in    = sec_ff;
      idle_in   = idle_ff;
      pend_in   = pend_ff;
      manual_in = manual_ff;
      mticks_in = mticks_ff;
      half_in   = half_ff;
      bcnt_in   = bcnt_ff;
      motor_in  = motor_ff;
      blue_in   = blue_ff;
      board_in  = board_ff;
      green_in  = green_ff;
      yellow_in = yellow_ff;
      idle_go   = 1'b0;
      blink_go  = 1'b0;
      pend_now  = pend_ff;

      if (manual_ff) begin
         if (item.well_empty_event) begin
            yellow_in = 1'b1;
            manual_in = 1'b0;
            mticks_in = '0;
            idle_go   = 1'b1;
         end else if (item.tick) begin
            blink_go  = 1'b1;
            mticks_in = mticks_dec;
            if (mticks_dec == '0) begin
               manual_in = 1'b0;
               idle_go   = 1'b1;
            end
         end
      end else begin
         // latest event wins, well empty over tank full in the same item
         if (item.well_empty_event) pend_now = STOP_EMPTY;
         else if (item.tank_full_event) pend_now = STOP_FULL;
         pend_in = pend_now;

         if (manual_type'(item.manual_request) != MANUAL_NONE) begin
            manual_in = 1'b1;
            motor_in  = 1'b1;
            blue_in   = 1'b1;
            bcnt_in   = '0;
            case (manual_type'(item.manual_request))
               MANUAL_1MIN: begin
                  half_in   = HALF_1;
                  mticks_in = MTICKS_1;
               end
               MANUAL_5MIN: begin
                  half_in   = HALF_5;
                  mticks_in = MTICKS_5;
               end
               default: begin
                  half_in   = HALF_10;
                  mticks_in = MTICKS_10;
               end
            endcase
            if (pend_now == STOP_EMPTY) begin
               yellow_in = 1'b1;
               manual_in = 1'b0;
               mticks_in = '0;
               idle_go   = 1'b1;
            end
            pend_in = STOP_NONE;
         end else begin
            case (phase_ff)
               MODE_WAIT: begin
                  if (sec_ff == '0 && sub_ff == '0 && item.well_high_level) begin
                     board_in = 1'b1;
                     phase_in = MODE_CHECK;
                  end else if (item.tick) begin
                     if (sub_ff == SUB_LAST) begin
                        sub_in = '0;
                        if (sec_ff == '0) begin
                           sec_in   = SEC_W'(1);
                           board_in = 1'b0;
                        end else begin
                           sec_in   = '0;
                           board_in = 1'b1;
                           if (idle_inc >= {1'b0, cfg.idle_blink_limit}) begin
                              // idle timeout: clear the idle count, pending stop, motor and every LED but the board LED
                              idle_in   = '0;
                              motor_in  = 1'b0;
                              blue_in   = 1'b0;
                              green_in  = 1'b0;
                              yellow_in = 1'b0;
                              pend_in   = STOP_NONE;
                           end else begin
                              idle_in = idle_inc[IDLE_W-1:0];
                           end
                        end
                     end else begin
                        sub_in = sub_ff + 1'b1;
                     end
                  end
               end
               MODE_CHECK: begin
                  if (item.tick) begin
                     if (sub_ff == SUB_LAST) begin
                        sub_in = '0;
                        if (!item.tank_low_level) begin
                           motor_in  = 1'b1;
                           blue_in   = 1'b1;
                           green_in  = 1'b0;
                           yellow_in = 1'b0;
                           half_in   = (cfg.auto_blink_ticks != '0) ?
                                       BLINK_W'(cfg.auto_blink_ticks) : BLINK_W'(1);
                           bcnt_in   = '0;
                           sec_in    = '0;
                           phase_in  = MODE_RUN;
                        end else begin
                           idle_go = 1'b1;
                        end
                     end else begin
                        sub_in = sub_ff + 1'b1;
                     end
                  end
               end
               MODE_RUN: begin
                  if (pend_now == STOP_FULL) begin
                     green_in = 1'b1;
                     idle_go  = 1'b1;
                  end else if (pend_now == STOP_EMPTY) begin
                     yellow_in = 1'b1;
                     idle_go   = 1'b1;
                  end else if (sec_ff >= run_limit) begin
                     green_in  = 1'b1;
                     yellow_in = 1'b1;
                     idle_go   = 1'b1;
                  end else if (item.tick) begin
                     blink_go = 1'b1;
                     if (sub_ff == SUB_LAST) begin
                        sub_in = '0;
                        sec_in = sec_ff + 1'b1;
                     end else begin
                        sub_in = sub_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  idle_go = 1'b1;
               end
            endcase
         end
      end

      if (blink_go) begin
         if (bcnt_inc >= {1'b0, half_ff}) begin
            bcnt_in = '0;
            blue_in = ~blue_ff;
         end else begin
            bcnt_in = bcnt_inc[BLINK_W-1:0];
         end
      end

      // back to the idle start; green and yellow keep their values
      if (idle_go) begin
         motor_in = 1'b0;
         blue_in  = 1'b0;
         board_in = 1'b0;
         pend_in  = STOP_NONE;
         phase_in = MODE_WAIT;
         sub_in   = '0;
         sec_in   = '0;
         idle_in  = '0;
         bcnt_in  = '0;
      end
   end

   always_comb begin
      rsp_next.motor_on   = motor_in;
      rsp_next.led_blue   = blue_in;
      rsp_next.led_board  = board_in;
      rsp_next.led_green  = green_in;
      rsp_next.led_yellow = yellow_in;
      rsp_next.mode       = manual_in ? MODE_MANUAL : phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= MODE_WAIT;
         sub_ff    <= '0;
         sec_ff    <= '0;
         idle_ff   <= '0;
         pend_ff   <= STOP_NONE;
         manual_ff <= 1'b0;
         mticks_ff <= '0;
         half_ff   <= HALF_RST;
         bcnt_ff   <= '0;
         motor_ff  <= 1'b0;
         blue_ff   <= 1'b0;
         board_ff  <= 1'b0;
         green_ff  <= 1'b0;
         yellow_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         sub_ff    <= sub_in;
         sec_ff    <= sec_in;
         idle_ff   <= idle_in;
         pend_ff   <= pend_in;
         manual_ff <= manual_in;
         mticks_ff <= mticks_in;
         half_ff   <= half_in;
         bcnt_ff   <= bcnt_in;
         motor_ff  <= motor_in;
         blue_ff   <= blue_in;
         board_ff  <= board_in;
         green_ff  <= green_in;
         yellow_ff <= yellow_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_manual_has_time: assert property (@(posedge clock) disable iff (reset)
      manual_ff |-> mticks_ff != '0)
      else $error("manual run active with no ticks left");

   a_blue_needs_motor: assert property (@(posedge clock) disable iff (reset)
      !motor_ff |-> !blue_ff)
      else $error("blue LED on with motor off");

   a_check_board_on: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == MODE_CHECK) |-> board_ff)
      else $error("board LED off while checking tank");

   a_sub_in_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff <= SUB_LAST)
      else $error("sub-second count out of range");
`endif

endmodule

// ----- design/well_pump_level_controller_unit.sv -----
// Top level of the well pump level controller: handshake stages and register file.
// Path: an accepted item waits in the input stage; the combinational next-state logic
// turns it into a result, taken into the result register once that register is free.
// Throughput: one item per cycle while rsp_ready stays high; a stalled result holds
// the input stage, which still takes one more item.
// Reset: synchronous, active high; control and config registers return to their defaults,
// the controller to waiting for the well level with all outputs off. No clearing pass.
module well_pump_level_controller_unit #(
   parameter int TICKS_PER_SECOND = wpl_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  wpl_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output wpl_pkg::rsp_type                rsp_item,
   input  logic                            csr_wr_en,
   input  logic [wpl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wpl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wpl_pkg::*;

   logic    stage_valid_ff;
   req_type stage_item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;
   cfg_type cfg_ff;
   rsp_type rsp_next;
   logic    out_free;
   logic    advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = stage_valid_ff && out_free;
   assign req_ready = !stage_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   wpl_core #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .item     (stage_item_ff),
      .cfg      (cfg_ff),
      .rsp_next (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_valid && req_ready) stage_valid_ff <= 1'b1;
         else if (advance) stage_valid_ff <= 1'b0;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) stage_item_ff <= req_item;
      if (advance) rsp_item_ff <= rsp_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_run_minutes  <= MAX_RUN_MINUTES_RST;
         cfg_ff.idle_blink_limit <= IDLE_BLINK_LIMIT_RST;
         cfg_ff.auto_blink_ticks <= AUTO_BLINK_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_RUN_MINUTES:  cfg_ff.max_run_minutes  <= csr_wdata[RUN_MIN_W-1:0];
            CSR_IDLE_BLINK_LIMIT: cfg_ff.idle_blink_limit <= csr_wdata[IDLE_W-1:0];
            CSR_AUTO_BLINK_TICKS: cfg_ff.auto_blink_ticks <= csr_wdata[ABLINK_W-1:0];
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stage_valid_ff)
      else $error("accepted item missing from input stage");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_free |=> stage_valid_ff && $stable(stage_item_ff))
      else $error("stalled item dropped from input stage");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item produced no result");
`endif

endmodule
